// ----- rtl/core/rsa_pkg.sv -----
// ----------------------------------------------------------------------------
// rsa_pkg: shared types and constants of the slot allocator
// table geometry, scan grouping, codes, word layouts and control structs
// ----------------------------------------------------------------------------
`default_nettype none

package rsa_pkg;

  localparam int SLOT_COUNT  = 256;
  localparam int COUNT_BITS  = 16;
  localparam int SLOT_BITS   = (SLOT_COUNT > 2) ? $clog2(SLOT_COUNT) : 1;
  localparam int HINT_BITS   = $clog2(SLOT_COUNT + 1);

  // free-slot scan looks at one group of in-use bits per cycle
  localparam int GROUP_SHIFT = 4;
  localparam int GROUP_SIZE  = 1 << GROUP_SHIFT;
  localparam int GROUP_COUNT = (SLOT_COUNT + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int GRP_BITS    = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
  localparam int PAD_COUNT   = GROUP_COUNT * GROUP_SIZE;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam int IDX_W    = 8;
  localparam int HANDLE_W = 32;
  localparam int POS_W    = 63;
  localparam int FLAGS_W  = 32;
  localparam int OP_W     = 2;
  localparam int RES_W    = 2;

  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 48;

  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_ADDREF  = 2'd2;

  localparam logic [RES_W-1:0] RES_OK     = 2'd0;
  localparam logic [RES_W-1:0] RES_FULL   = 2'd1;
  localparam logic [RES_W-1:0] RES_UNUSED = 2'd2;
  localparam logic [RES_W-1:0] RES_SAT    = 2'd3;

  typedef struct packed {
    logic take;
    logic scan;
    logic commit;
  } rsa_cmd_t;

  typedef struct packed {
    logic scan_hit;
    logic scan_last;
    logic out_free;
  } rsa_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/rsa_ctrl.sv -----
// ----------------------------------------------------------------------------
// rsa_ctrl: request sequencer
// takes one request, runs the free-slot scan for allocates, then commits
// ----------------------------------------------------------------------------
`default_nettype none

module rsa_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    s_axis_tvalid,
  input  wire logic [rsa_pkg::OP_W-1:0] op,
  input  wire rsa_pkg::rsa_status_t    status,
  output logic                         s_axis_tready,
  output rsa_pkg::rsa_cmd_t            cmd
);
  import rsa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = (op == OP_ALLOC) ? S_SCAN : S_EXEC;
        end
      end
      S_SCAN: begin
        if (status.scan_hit || status.scan_last) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign s_axis_tready = (state == S_IDLE);
  assign cmd.take      = (state == S_IDLE) && s_axis_tvalid;
  assign cmd.scan      = (state == S_SCAN);
  assign cmd.commit    = (state == S_EXEC) && status.out_free;

endmodule

`default_nettype wire

// ----- rtl/core/rsa_dp.sv -----
// ----------------------------------------------------------------------------
// rsa_dp: slot table datapath
// in-use bits, hint, group scan, slot memories and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module rsa_dp (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire rsa_pkg::rsa_cmd_t               cmd,
  input  wire logic [rsa_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input  wire logic [rsa_pkg::OP_W-1:0]        s_axis_tuser,
  output rsa_pkg::rsa_status_t                 status,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [rsa_pkg::OUT_DATA_W-1:0]       m_axis_tdata
);
  import rsa_pkg::*;

  // table storage
  logic [COUNT_BITS-1:0] count_mem  [SLOT_COUNT];
  logic [HANDLE_W-1:0]   handle_mem [SLOT_COUNT];
  logic [POS_W-1:0]      pos_mem    [SLOT_COUNT];
  logic [FLAGS_W-1:0]    flags_mem  [SLOT_COUNT];

  logic [SLOT_COUNT-1:0] in_use;
  logic [PAD_COUNT-1:0]  in_use_pad;
  logic [HINT_BITS-1:0]  hint;

  // latched request
  logic [OP_W-1:0]     req_op;
  logic [IDX_W-1:0]    req_slot;
  logic                req_close;
  logic [HANDLE_W-1:0] req_handle;
  logic [POS_W-1:0]    req_pos;
  logic [FLAGS_W-1:0]  req_flags;

  logic [COUNT_BITS-1:0] count_q;
  logic [HANDLE_W-1:0]   handle_q;

  // scan
  logic [GRP_BITS-1:0]   grp;
  logic [GROUP_SIZE-1:0] grp_used;
  logic                  hit;
  logic [GROUP_SHIFT-1:0] hit_pos;
  logic [SLOT_BITS-1:0]  cand_slot;
  logic [SLOT_BITS-1:0]  sel_slot;
  logic                  found;

  // execute
  logic [IDX_W-1:0]      in_slot;
  logic [SLOT_BITS-1:0]  in_addr;
  logic [SLOT_BITS-1:0]  req_addr;
  logic                  in_range;
  logic [COUNT_BITS-1:0] cnt;
  logic                  wr_en;
  logic [SLOT_BITS-1:0]  wr_addr;
  logic [COUNT_BITS-1:0] wr_count;
  logic                  alloc_ok;
  logic                  do_free;
  logic [IDX_W-1:0]      res_slot;
  logic [RES_W-1:0]      res_code;
  logic                  res_close;
  logic [HANDLE_W-1:0]   res_handle;

  assign in_slot  = s_axis_tdata[IDX_W-1:0];
  assign in_addr  = SLOT_BITS'(in_slot);
  assign req_addr = SLOT_BITS'(req_slot);
  assign in_range = 32'(req_slot) < SLOT_COUNT;

  always_comb begin
    in_use_pad = '1;
    in_use_pad[SLOT_COUNT-1:0] = in_use;
  end

  assign grp_used = in_use_pad[(32'(grp) << GROUP_SHIFT) +: GROUP_SIZE];

  always_comb begin
    hit     = 1'b0;
    hit_pos = '0;
    for (int j = GROUP_SIZE - 1; j >= 0; j--) begin
      if (!grp_used[j] && (((32'(grp) << GROUP_SHIFT) | 32'(j)) >= 32'(hint))) begin
        hit     = 1'b1;
        hit_pos = GROUP_SHIFT'(j);
      end
    end
  end

  assign cand_slot = SLOT_BITS'((32'(grp) << GROUP_SHIFT) | 32'(hit_pos));

  assign status.scan_hit  = hit;
  assign status.scan_last = (32'(grp) == GROUP_COUNT - 1) || (32'(hint) >= SLOT_COUNT);
  assign status.out_free  = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      req_op     <= s_axis_tuser;
      req_slot   <= in_slot;
      req_close  <= s_axis_tdata[IDX_W];
      req_handle <= s_axis_tdata[IDX_W+1 +: HANDLE_W];
      req_pos    <= s_axis_tdata[IDX_W+1+HANDLE_W +: POS_W];
      req_flags  <= s_axis_tdata[IDX_W+1+HANDLE_W+POS_W +: FLAGS_W];
      count_q    <= count_mem[in_addr];
      handle_q   <= handle_mem[in_addr];
      grp        <= GRP_BITS'(32'(hint) >> GROUP_SHIFT);
    end
    if (cmd.scan) begin
      found <= hit;
      if (hit) begin
        sel_slot <= cand_slot;
      end else begin
        grp <= grp + 1'b1;
      end
    end
  end

  always_comb begin
    cnt        = (in_range && in_use[req_addr]) ? count_q : '0;
    wr_en      = 1'b0;
    wr_addr    = req_addr;
    wr_count   = cnt;
    alloc_ok   = 1'b0;
    do_free    = 1'b0;
    res_slot   = req_slot;
    res_code   = RES_OK;
    res_close  = 1'b0;
    res_handle = '0;
    case (req_op)
      OP_ALLOC: begin
        if (found) begin
          alloc_ok = 1'b1;
          wr_en    = 1'b1;
          wr_addr  = sel_slot;
          wr_count = COUNT_BITS'(1);
          res_slot = IDX_W'(sel_slot);
        end else begin
          res_slot = '0;
          res_code = RES_FULL;
        end
      end
      OP_RELEASE: begin
        if (cnt == '0) begin
          res_code = RES_UNUSED;
        end else begin
          wr_en    = 1'b1;
          wr_count = cnt - 1'b1;
          if (cnt == COUNT_BITS'(1)) begin
            do_free = 1'b1;
            if (req_close) begin
              res_close  = 1'b1;
              res_handle = handle_q;
            end
          end
        end
      end
      OP_ADDREF: begin
        if (cnt == '0) begin
          res_code = RES_UNUSED;
        end else if (cnt == COUNT_MAX) begin
          res_code = RES_SAT;
        end else begin
          wr_en    = 1'b1;
          wr_count = cnt + 1'b1;
        end
      end
      default: res_code = RES_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      count_mem[wr_addr] <= wr_count;
    end
    if (cmd.commit && alloc_ok) begin
      handle_mem[sel_slot] <= req_handle;
      pos_mem[sel_slot]    <= req_pos;
      flags_mem[sel_slot]  <= req_flags;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= '0;
      hint   <= '0;
    end else if (cmd.commit) begin
      if (alloc_ok) begin
        in_use[sel_slot] <= 1'b1;
        hint             <= HINT_BITS'(32'(sel_slot) + 1);
      end
      if (do_free) begin
        in_use[req_addr] <= 1'b0;
        if (32'(req_slot) < 32'(hint)) begin
          hint <= HINT_BITS'(req_slot);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_axis_tdata <= {4'b0, res_handle, res_close, do_free, res_code, res_slot};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/refcounted_slot_allocator.sv -----
// ----------------------------------------------------------------------------
// refcounted_slot_allocator: reference-counted open-file slot table
// allocate grants the lowest free slot, release and add-reference adjust
// a slot's count, a release that frees a slot may ask for a handle close
//
// one request word in on the s_axis channel, one result word out on m_axis
// for every request. requests are handled one at a time. for release,
// add-reference and the unused code, the accept cycle reads the count and
// handle memories, then the commit step writes the result register.
// allocate scans between the two: the free-slot scan walks 1 to 16 groups
// of 16 in-use bits upward from the lowest-free hint, one group a cycle.
// the result sits in an output register, so the next request is accepted
// while it waits; a stalled receiver only holds a finished request in its
// commit step until the result register frees up.
// reset clears every in-use bit and the hint, so all slots are
// free right after reset; the slot memories need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module refcounted_slot_allocator (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // slot_index, close_on_free, handle_in, position_in, flags_in
  input  wire logic [rsa_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // operation
  input  wire logic [rsa_pkg::OP_W-1:0]         s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // granted_slot, result_code, slot_freed, close_request, close_handle
  output logic [rsa_pkg::OUT_DATA_W-1:0]        m_axis_tdata
);
  import rsa_pkg::*;

  rsa_cmd_t    cmd;
  rsa_status_t status;

  rsa_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .op            (s_axis_tuser),
    .status        (status),
    .s_axis_tready (s_axis_tready),
    .cmd           (cmd)
  );

  rsa_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .status        (status),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while another is in flight");

  // a result only comes out of a commit step
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result without a commit step");

  // a freed slot always reports success
  a_freed_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[10] |-> m_axis_tdata[9:8] == RES_OK)
    else $error("freed slot with error code");

endmodule

`default_nettype wire

// ----- tb/rsa_grant_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_grant_checker: result checker for the slot allocator
// watches both stream channels, keeps its own slot table and hint, predicts
// the result word of every accepted request and compares the result words
// in order, field by field
// ----------------------------------------------------------------------------
module rsa_grant_checker
  import rsa_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  input  wire logic                  s_axis_tready,
  // slot_index, close_on_free, handle_in, position_in, flags_in
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // operation
  input  wire logic [OP_W-1:0]       s_axis_tuser,
  input  wire logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // granted_slot, result_code, slot_freed, close_request, close_handle
  input  wire logic [OUT_DATA_W-1:0] m_axis_tdata,
  output int                         errors,
  output int                         pending
);

  typedef struct packed {
    logic [HANDLE_W-1:0] close_handle;
    logic                close_request;
    logic                slot_freed;
    logic [RES_W-1:0]    code;
    logic [IDX_W-1:0]    slot;
  } grant_t;

  grant_t grant_q[$];

  logic [COUNT_BITS-1:0] ref_cnt  [SLOT_COUNT];
  logic [HANDLE_W-1:0]   slot_hdl [SLOT_COUNT];
  logic [POS_W-1:0]      slot_pos [SLOT_COUNT];
  logic [FLAGS_W-1:0]    slot_flg [SLOT_COUNT];
  logic [HINT_BITS-1:0]  free_hint;

  initial errors = 0;

  function automatic grant_t predict_grant(input logic [OP_W-1:0] op,
                                           input logic [IN_DATA_W-1:0] d);
    grant_t g;
    int i;
    logic [IDX_W-1:0] idx;
    idx = d[7:0];
    g = '0;
    g.slot = idx;
    case (op)
      OP_ALLOC: begin
        i = int'(free_hint);
        while (i < SLOT_COUNT && ref_cnt[i] != '0) i++;
        if (i < SLOT_COUNT) begin
          ref_cnt[i]  = COUNT_BITS'(1);
          slot_hdl[i] = d[40:9];
          slot_pos[i] = d[103:41];
          slot_flg[i] = d[135:104];
          free_hint   = HINT_BITS'(i + 1);
          g.slot      = i[IDX_W-1:0];
        end else begin
          g.slot = '0;
          g.code = RES_FULL;
        end
      end
      OP_RELEASE: begin
        if (ref_cnt[idx] == '0) begin
          g.code = RES_UNUSED;
        end else begin
          ref_cnt[idx] = ref_cnt[idx] - 1'b1;
          if (ref_cnt[idx] == '0) begin
            g.slot_freed = 1'b1;
            if (d[8]) begin
              g.close_request = 1'b1;
              g.close_handle  = slot_hdl[idx];
            end
            slot_hdl[idx] = '0;
            slot_pos[idx] = '0;
            slot_flg[idx] = '0;
            if (HINT_BITS'(idx) < free_hint) free_hint = HINT_BITS'(idx);
          end
        end
      end
      OP_ADDREF: begin
        if (ref_cnt[idx] == '0) g.code = RES_UNUSED;
        else if (ref_cnt[idx] == COUNT_MAX) g.code = RES_SAT;
        else ref_cnt[idx] = ref_cnt[idx] + 1'b1;
      end
      default: begin
      end
    endcase
    return g;
  endfunction

  always @(posedge clk) begin
    grant_t got;
    grant_t want;
    if (rst) begin
      for (int k = 0; k < SLOT_COUNT; k++) ref_cnt[k] = '0;
      free_hint = '0;
      grant_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[$bits(grant_t)-1:0];
        if (grant_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result word %h", m_axis_tdata);
        end else begin
          want = grant_q.pop_front();
          if (got.slot !== want.slot || got.code !== want.code ||
              got.slot_freed !== want.slot_freed ||
              got.close_request !== want.close_request ||
              got.close_handle !== want.close_handle) begin
            errors++;
            if (errors <= 10)
              $display("result mismatch (exp/got): slot %0d/%0d code %0d/%0d freed %b/%b",
                       want.slot, got.slot, want.code, got.code,
                       want.slot_freed, got.slot_freed,
                       "  close %b/%b handle %h/%h",
                       want.close_request, got.close_request,
                       want.close_handle, got.close_handle);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        grant_q.push_back(predict_grant(s_axis_tuser, s_axis_tdata));
    end
    pending <= grant_q.size();
  end

endmodule

// ----- tb/tb_refcounted_slot_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_refcounted_slot_allocator: testbench of the slot allocator
// directed requests on the corner cases, a table filled past full, then
// random churn under several idle and stall mixes; a separate checker
// predicts and compares every result word
// ----------------------------------------------------------------------------
module tb_refcounted_slot_allocator;
  import rsa_pkg::*;

  localparam logic [OP_W-1:0] OP_NONE = 2'd3;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 5000;

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [OP_W-1:0]       s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  int send_idle  = 0;
  int recv_stall = 0;
  int hold_req   = 0;
  int hold_seen  = 0;
  int hold_left  = 0;
  int quiet      = 0;
  int errors;
  int pending;

  always #5 clk = ~clk;

  refcounted_slot_allocator DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  rsa_grant_checker u_grant_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .errors        (errors),
    .pending       (pending)
  );

  // receiver: random stalls, or a long hold-off when asked
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen     <= hold_req;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("tb_refcounted_slot_allocator: done, errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic logic [POS_W-1:0] rand_pos();
    logic [63:0] p;
    p = {$urandom, $urandom};
    return p[POS_W-1:0];
  endfunction

  task automatic send_word(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                           input logic close, input logic [HANDLE_W-1:0] handle,
                           input logic [POS_W-1:0] pos, input logic [FLAGS_W-1:0] flags);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {flags, pos, handle, close, idx};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic churn(input int n, input int idle, input int stall);
    int pick;
    logic [OP_W-1:0] op;
    logic [IDX_W-1:0] idx;
    send_idle = idle;
    recv_stall <= stall;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 40) op = OP_ALLOC;
      else if (pick < 75) op = OP_RELEASE;
      else if (pick < 95) op = OP_ADDREF;
      else op = OP_NONE;
      idx = $urandom_range(1) ? IDX_W'($urandom_range(31)) : IDX_W'($urandom_range(255));
      send_word(op, idx, 1'($urandom_range(1)), $urandom, rand_pos(), $urandom);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners
    send_word(OP_ALLOC,   8'd0,   1'b0, '1, '1, '1);
    send_word(OP_ALLOC,   8'd255, 1'b1, '0, '0, '0);
    send_word(OP_ALLOC,   8'd7,   1'b0, $urandom, rand_pos(), $urandom);
    send_word(OP_ADDREF,  8'd0,   1'b0, '0, '0, '0);
    send_word(OP_RELEASE, 8'd0,   1'b1, '0, '0, '0);
    send_word(OP_RELEASE, 8'd0,   1'b1, '0, '0, '0);
    send_word(OP_RELEASE, 8'd0,   1'b1, '0, '0, '0);
    send_word(OP_ADDREF,  8'd0,   1'b0, '0, '0, '0);
    send_word(OP_RELEASE, 8'd1,   1'b0, '1, '1, '1);
    send_word(OP_ALLOC,   8'd0,   1'b0, $urandom, rand_pos(), $urandom);
    send_word(OP_ALLOC,   8'd0,   1'b0, $urandom, rand_pos(), $urandom);
    send_word(OP_RELEASE, 8'd255, 1'b1, '0, '0, '0);
    send_word(OP_ADDREF,  8'd255, 1'b1, '0, '0, '0);
    send_word(OP_NONE,    8'd255, 1'b1, '1, '1, '1);
    send_word(OP_NONE,    8'd0,   1'b0, '0, '0, '0);
    send_word(OP_RELEASE, 8'd2,   1'b1, '0, '0, '0);

    // fill the table past full, then free every fourth slot
    repeat (SLOT_COUNT + 4)
      send_word(OP_ALLOC, IDX_W'($urandom_range(255)), 1'b0, $urandom, rand_pos(), $urandom);
    send_word(OP_ADDREF,  8'd255, 1'b0, '0, '0, '0);
    send_word(OP_RELEASE, 8'd255, 1'b1, '0, '0, '0);
    for (int i = 1; i < SLOT_COUNT; i += 4)
      send_word(OP_RELEASE, i[IDX_W-1:0], 1'($urandom_range(1)), '0, '0, '0);

    // random churn
    hold_req <= hold_req + 1;
    churn(28, 0, 0);
    churn(28, 73, 0);
    send_idle = 0;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    churn(28, 0, 73);
    churn(28, 22, 22);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) $display("tb_refcounted_slot_allocator: done, clean");
    else $display("tb_refcounted_slot_allocator: done, errors");
    $finish;
  end

endmodule
